/* rtl/core/terminal_escape_key_decoder_top_assert.svh */
// ----------------------------------------------------------------------------
// Terminal escape key decoder assertion macros
// Short forms for the concurrent checks of the decoder, clocked on clk_i and
// held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TERMINAL_ESCAPE_KEY_DECODER_TOP_ASSERT_SVH
`define TERMINAL_ESCAPE_KEY_DECODER_TOP_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define TEKD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// When the trigger holds, the result must hold at the next clock edge.
`define TEKD_ASSERT_NEXT(label, trig, res, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (res)) \
    else $error(msg);

`endif

/* rtl/core/tekd_pkg.sv */
// ----------------------------------------------------------------------------
// Terminal escape key decoder package
// Decode modes, event kinds, character constants and special key codes.
// ----------------------------------------------------------------------------
package tekd_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_CSI  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    FUNC_BYTE    = 2'd0,
    FUNC_TIMEOUT = 2'd1,
    FUNC_ALARM   = 2'd2,
    FUNC_UNUSED  = 2'd3
  } func_e;

  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_A        = 8'h41;
  localparam logic [7:0] CH_B        = 8'h42;
  localparam logic [7:0] CH_C        = 8'h43;
  localparam logic [7:0] CH_D        = 8'h44;
  localparam logic [7:0] CH_TILDE    = 8'h7E;
  localparam logic [7:0] CH_0        = 8'h30;
  localparam logic [7:0] CH_9        = 8'h39;

  localparam logic [7:0] KEY_LEFT   = 8'd0;
  localparam logic [7:0] KEY_RIGHT  = 8'd1;
  localparam logic [7:0] KEY_UP     = 8'd2;
  localparam logic [7:0] KEY_DOWN   = 8'd3;
  localparam logic [7:0] KEY_INSERT = 8'd4;
  localparam logic [7:0] KEY_DELETE = 8'd5;
  localparam logic [7:0] KEY_HOME   = 8'd6;
  localparam logic [7:0] KEY_END    = 8'd7;
  localparam logic [7:0] KEY_PGUP   = 8'd8;
  localparam logic [7:0] KEY_PGDN   = 8'd9;
  localparam logic [7:0] KEY_TICK   = 8'd10;

  localparam int unsigned ArgWidth = 16;

  // Editing key selected by the argument of an "ESC [ n ~" sequence.
  function automatic logic [7:0] tilde_key(input logic [2:0] arg);
    logic [7:0] key;
    case (arg)
      3'd1:    key = KEY_HOME;
      3'd2:    key = KEY_INSERT;
      3'd3:    key = KEY_DELETE;
      3'd4:    key = KEY_END;
      3'd5:    key = KEY_PGUP;
      3'd6:    key = KEY_PGDN;
      default: key = KEY_TICK;
    endcase
    return key;
  endfunction

endpackage

/* rtl/core/terminal_escape_key_decoder_top.sv */
// ----------------------------------------------------------------------------
// Terminal escape key decoder
// Turns a stream of keyboard events into plain bytes and decoded keys.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one event per transfer: func_i selects a received
// byte, a read timeout or a timer alarm, and rx_byte_i holds the byte. Each
// event gives zero or one result on the output channel: is_special_o tells a
// decoded key (arrows, editing keys, tick) from a plain byte in key_code_o.
// Both channels use valid and stall; a transfer happens at a rising edge with
// valid high and stall low.
// An event is captured in an input register and decoded into the result
// register when that register is free, and the result leaves from there. One
// event per cycle is sustained while out_stall_i stays low; the single pass of
// decode logic between the two registers sets that figure.
// When the receiver stalls, the result register holds its result; the input
// register still takes one more event, and in_stall_o rises only once both
// registers are full. An event waits in the input register for a free result
// register even when it gives no result.
// Reset returns the decoder to idle with a zero argument and empties both
// registers.
module terminal_escape_key_decoder_top
  import tekd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] func_i,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       is_special_o,
  output logic [7:0] key_code_o
);

  logic                s1_valid_q, s1_valid_d;
  logic [1:0]          s1_func_q;
  logic [7:0]          s1_byte_q;
  logic                out_valid_q, out_valid_d;
  logic                out_special_q;
  logic [7:0]          out_code_q;
  mode_e               mode_q, mode_d;
  logic [ArgWidth-1:0] arg_q, arg_d;

  logic                in_accept;
  logic                out_free;
  logic                s1_adv;
  logic                res_valid;
  logic                res_special;
  logic [7:0]          res_code;
  logic [3:0]          digit;
  logic                arg_in_range;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign digit        = 4'(s1_byte_q - CH_0);
  assign arg_in_range = (arg_q[ArgWidth-1:3] == '0) && (arg_q[2:0] != 3'd0)
                        && (arg_q[2:0] != 3'd7);

  always_comb begin
    mode_d      = mode_q;
    arg_d       = arg_q;
    res_valid   = 1'b0;
    res_special = 1'b0;
    res_code    = s1_byte_q;
    if (s1_adv) begin
      case (func_e'(s1_func_q))
        FUNC_ALARM: begin
          res_valid   = 1'b1;
          res_special = 1'b1;
          res_code    = KEY_TICK;
        end
        FUNC_TIMEOUT: begin
          if (mode_q == MODE_ESC || mode_q == MODE_CSI) begin
            mode_d    = MODE_IDLE;
            res_valid = 1'b1;
            res_code  = CH_ESC;
          end
        end
        FUNC_BYTE: begin
          case (mode_q)
            MODE_ESC: begin
              if (s1_byte_q == CH_LBRACKET) begin
                mode_d = MODE_CSI;
                arg_d  = '0;
              end else begin
                // The byte after a lone ESC is dropped.
                mode_d    = MODE_IDLE;
                res_valid = 1'b1;
                res_code  = CH_ESC;
              end
            end
            MODE_CSI: begin
              if (s1_byte_q >= CH_0 && s1_byte_q <= CH_9) begin
                // Times ten as two shifts; the sum wraps at the argument width.
                arg_d = (arg_q << 3) + (arg_q << 1) + ArgWidth'(digit);
              end else begin
                mode_d      = MODE_IDLE;
                res_special = 1'b1;
                if (s1_byte_q == CH_A) begin
                  res_valid = 1'b1;
                  res_code  = KEY_UP;
                end else if (s1_byte_q == CH_B) begin
                  res_valid = 1'b1;
                  res_code  = KEY_DOWN;
                end else if (s1_byte_q == CH_C) begin
                  res_valid = 1'b1;
                  res_code  = KEY_RIGHT;
                end else if (s1_byte_q == CH_D) begin
                  res_valid = 1'b1;
                  res_code  = KEY_LEFT;
                end else if (s1_byte_q == CH_TILDE && arg_in_range) begin
                  res_valid = 1'b1;
                  res_code  = tilde_key(arg_q[2:0]);
                end
              end
            end
            default: begin
              if (s1_byte_q == CH_ESC) begin
                mode_d = MODE_ESC;
              end else begin
                mode_d    = MODE_IDLE;
                res_valid = 1'b1;
              end
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = s1_adv && res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_IDLE;
      arg_q       <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      mode_q      <= mode_d;
      arg_q       <= arg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_func_q <= func_i;
      s1_byte_q <= rx_byte_i;
    end
    if (s1_adv && res_valid) begin
      out_special_q <= res_special;
      out_code_q    <= res_code;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign is_special_o = out_special_q;
  assign key_code_o   = out_code_q;

  `include "terminal_escape_key_decoder_top_assert.svh"

  `TEKD_ASSERT_ALWAYS(a_stall_only_when_full, !in_stall_o || (s1_valid_q && out_valid_q), "input stalled with a free stage")
  `TEKD_ASSERT_NEXT(a_alarm_gives_tick, s1_adv && s1_func_q == FUNC_ALARM, out_valid_o && is_special_o && key_code_o == KEY_TICK, "alarm did not give a tick")
  `TEKD_ASSERT_NEXT(a_alarm_keeps_mode, s1_adv && s1_func_q == FUNC_ALARM, $stable(mode_q) && $stable(arg_q), "alarm changed the decode state")
  `TEKD_ASSERT_NEXT(a_timeout_in_seq, s1_adv && s1_func_q == FUNC_TIMEOUT && mode_q != MODE_IDLE, mode_q == MODE_IDLE && out_valid_o && !is_special_o && key_code_o == CH_ESC, "timeout in a sequence did not give ESC")

endmodule
